### sv/gsk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsk_pkg
// Shared constants, codes and handshake structs of the seed/key responder.
// ----------------------------------------------------------------------------
package gsk_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DIGIT_W = 8;

  // frame type nibble
  localparam logic [3:0] CMD_FIRST  = 4'h1;
  localparam logic [3:0] CMD_CONSEC = 4'h2;
  localparam logic [3:0] CMD_FLOW   = 4'h3;

  // stage codes, used as received selector and as reply byte 1
  localparam logic [7:0] SUB_01 = 8'h01;
  localparam logic [7:0] SUB_02 = 8'h02;
  localparam logic [7:0] SUB_03 = 8'h03;
  localparam logic [7:0] SUB_41 = 8'h41;
  localparam logic [7:0] SUB_42 = 8'h42;

  // reply byte 0
  localparam logic [7:0] RSP_SESSION  = 8'h10;
  localparam logic [7:0] RSP_SECURITY = 8'h27;
  localparam logic [7:0] RSP_ROUTINE  = 8'h31;

  // fixed reply bytes
  localparam logic [7:0] FILL_AA = 8'haa;
  localparam logic [7:0] FILL_FF = 8'hff;
  localparam logic [7:0] EXT_0D  = 8'h0d;

  localparam logic [3:0] LEN_2 = 4'd2;
  localparam logic [3:0] LEN_4 = 4'd4;
  localparam logic [3:0] LEN_5 = 4'd5;
  localparam logic [3:0] LEN_6 = 4'd6;

  // key one: modular exponentiation with the wrapping barrett step
  localparam logic [12:0]       EXP1     = 13'h12e5;
  localparam logic [15:0]       MOD1     = 16'h3eab;
  localparam logic [WORD_W-1:0] NEG_MOD1 = 32'h0 - {16'h0, MOD1};
  localparam logic [15:0]       BMAG_LO  = 16'h7f05;
  localparam logic [15:0]       BMAG_HI  = 16'h82b8;
  localparam logic [7:0]        MIX_XOR  = 8'h0f;
  localparam logic [WORD_W-1:0] XOR1     = 32'had0779e2;

  // key two: shift-feedback iteration
  localparam logic [6:0]        K2_BASE = 7'd37;
  localparam logic [7:0]        K2_MASK = 8'h1c;
  localparam logic [7:0]        K2_FLIP = 8'h08;
  localparam logic [WORD_W-1:0] XOR2    = 32'hdc8fe1ae;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] seed;
  } key_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] key;
  } key_rsp_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic            send;
    logic            done;
    logic [3:0]      len;
    logic [5:0][7:0] tx;
  } reply_t;

endpackage
`default_nettype wire

### sv/gsk_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsk channels
// Valid/ready channels: received frame, reply frame and configuration write.
// ----------------------------------------------------------------------------
interface gsk_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] rx_byte0;
  logic [7:0] rx_byte1;
  logic [7:0] rx_byte2;
  logic [7:0] rx_byte3;
  logic [7:0] rx_byte4;

  modport source (output valid, command, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
                  rx_byte4, input ready);
  modport sink (input valid, command, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
                rx_byte4, output ready);
endinterface

interface gsk_out_if;
  logic        valid;
  logic        ready;
  logic        send_frame;
  logic        auth_done;
  logic [3:0]  frame_length;
  logic [10:0] response_frame_id;
  logic [7:0]  tx_byte0;
  logic [7:0]  tx_byte1;
  logic [7:0]  tx_byte2;
  logic [7:0]  tx_byte3;
  logic [7:0]  tx_byte4;
  logic [7:0]  tx_byte5;

  modport source (output valid, send_frame, auth_done, frame_length, response_frame_id,
                  tx_byte0, tx_byte1, tx_byte2, tx_byte3, tx_byte4, tx_byte5,
                  input ready);
  modport sink (input valid, send_frame, auth_done, frame_length, response_frame_id,
                tx_byte0, tx_byte1, tx_byte2, tx_byte3, tx_byte4, tx_byte5,
                output ready);
endinterface

interface gsk_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] response_id;

  modport source (output valid, response_id, input ready);
  modport sink (input valid, response_id, output ready);
endinterface
`default_nettype wire

### sv/gsk_mulser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsk_mulser
// Digit-serial multiply-accumulate: p = acc + a * b, low 32 bits, one digit of
// b per cycle, stopping as soon as the remaining digits of b are zero.
// ----------------------------------------------------------------------------
module gsk_mulser import gsk_pkg::*; #(
  parameter int unsigned DigitW = DIGIT_W
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [WORD_W-1:0]        p_q, p_d, a_q, a_d, b_q, b_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [WORD_W-1:0]        part;

  always_comb begin
    part   = a_q * WORD_W'(b_q[DigitW-1:0]);
    p_d    = p_q;
    a_d    = a_q;
    b_d    = b_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      p_d    = req_i.acc;
      a_d    = req_i.a;
      b_d    = req_i.b;
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d = p_q + part;
      a_d = a_q << DigitW;
      b_d = b_q >> DigitW;
      if (b_d == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule
`default_nettype wire

### sv/gsk_key1.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsk_key1
// Key one: square-and-multiply over the exponent bits, each product reduced by
// the wrapping barrett step, all on one digit-serial multiplier; byte mix last.
// ----------------------------------------------------------------------------
module gsk_key1 import gsk_pkg::*; #(
  parameter int unsigned DigitW = DIGIT_W
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  key_req_t req_i,
  output key_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    K_IDLE  = 4'b0001,
    K_ISSUE = 4'b0010,
    K_WAIT  = 4'b0100,
    K_DONE  = 4'b1000
  } kst_e;

  // multiplier passes of one multiply-reduce
  typedef enum logic [5:0] {
    PH_MUL = 6'b000001,
    PH_LL  = 6'b000010,
    PH_LH  = 6'b000100,
    PH_HL  = 6'b001000,
    PH_HH  = 6'b010000,
    PH_RED = 6'b100000
  } ph_e;

  kst_e              st_q, st_d;
  ph_e               ph_q, ph_d, ph_nxt;
  logic [12:0]       e_q, e_d;
  logic              sel_acc_q, sel_acc_d;
  logic [WORD_W-1:0] acc_q, acc_d, base_q, base_d, v_q, v_d;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  logic [7:0]        sum8, m8;
  logic [15:0]       mix16;

  gsk_mulser #(.DigitW(DigitW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_comb begin
    mul_req       = '0;
    mul_req.start = (st_q == K_ISSUE);
    unique case (ph_q)
      PH_MUL: begin
        mul_req.a = sel_acc_q ? acc_q : base_q;
        mul_req.b = base_q;
      end
      PH_LL: begin
        mul_req.a = {16'h0, v_q[15:0]};
        mul_req.b = {16'h0, BMAG_LO};
      end
      PH_LH: begin
        mul_req.acc = {16'h0, mul_rsp.p[31:16]};
        mul_req.a   = {16'h0, v_q[15:0]};
        mul_req.b   = {16'h0, BMAG_HI};
      end
      PH_HL: begin
        mul_req.acc = mul_rsp.p;
        mul_req.a   = {16'h0, v_q[31:16]};
        mul_req.b   = {16'h0, BMAG_LO};
      end
      PH_HH: begin
        mul_req.acc = {16'h0, mul_rsp.p[31:16]};
        mul_req.a   = {16'h0, v_q[31:16]};
        mul_req.b   = {16'h0, BMAG_HI};
      end
      PH_RED: begin
        // v - q * mod, q = t >> 13
        mul_req.acc = v_q;
        mul_req.a   = NEG_MOD1;
        mul_req.b   = {13'h0, mul_rsp.p[31:13]};
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (ph_q)
      PH_MUL:  ph_nxt = PH_LL;
      PH_LL:   ph_nxt = PH_LH;
      PH_LH:   ph_nxt = PH_HL;
      PH_HL:   ph_nxt = PH_HH;
      PH_HH:   ph_nxt = PH_RED;
      default: ph_nxt = PH_MUL;
    endcase
  end

  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q;
    e_d       = e_q;
    sel_acc_d = sel_acc_q;
    acc_d     = acc_q;
    base_d    = base_q;
    v_d       = v_q;
    unique case (st_q)
      K_IDLE: begin
        if (req_i.start) begin
          acc_d     = 32'd1;
          base_d    = {16'h0, req_i.seed[15:0]};
          e_d       = EXP1;
          sel_acc_d = EXP1[0];
          ph_d      = PH_MUL;
          st_d      = K_ISSUE;
        end
      end
      K_ISSUE: st_d = K_WAIT;
      K_WAIT: begin
        if (mul_rsp.done) begin
          st_d = K_ISSUE;
          ph_d = ph_nxt;
          if (ph_q == PH_MUL) begin
            v_d = mul_rsp.p;
          end
          if (ph_q == PH_RED) begin
            if (sel_acc_q) begin
              acc_d     = mul_rsp.p;
              sel_acc_d = 1'b0;
            end else begin
              base_d    = mul_rsp.p;
              e_d       = e_q >> 1;
              sel_acc_d = e_q[1];
              if (e_q[12:1] == '0) begin
                st_d = K_DONE;
              end
            end
          end
        end
      end
      K_DONE:  st_d = K_IDLE;
      default: st_d = K_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= K_IDLE;
      ph_q      <= PH_MUL;
      e_q       <= '0;
      sel_acc_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      ph_q      <= ph_d;
      e_q       <= e_d;
      sel_acc_q <= sel_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    v_q    <= v_d;
  end

  // byte mix of the low half, mirrored into both halves
  always_comb begin
    sum8  = acc_q[15:8] + acc_q[7:0];
    m8    = sum8 ^ MIX_XOR;
    mix16 = {acc_q[15:8] ^ m8, acc_q[7:0] ^ m8};
  end

  assign rsp_o.done = (st_q == K_DONE);
  assign rsp_o.key  = {mix16, mix16} ^ XOR1;

endmodule
`default_nettype wire

### sv/gsk_key2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsk_key2
// Key two: 32-bit shift register, one feedback bit shifted in per cycle for a
// seed-dependent count of 37 to 65 shifts.
// ----------------------------------------------------------------------------
module gsk_key2 import gsk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  key_req_t req_i,
  output key_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_RUN  = 3'b010,
    L_DONE = 3'b100
  } lst_e;

  lst_e              st_q, st_d;
  logic [6:0]        n_q, n_d;
  logic [WORD_W-1:0] s_q, s_d;
  logic              fb;

  // the nested shift/xor chain reduces to four taps
  assign fb = s_q[30] ^ s_q[24] ^ s_q[12] ^ s_q[2];

  always_comb begin
    st_d = st_q;
    n_d  = n_q;
    s_d  = s_q;
    unique case (st_q)
      L_IDLE: begin
        if (req_i.start) begin
          s_d  = req_i.seed;
          n_d  = K2_BASE + 7'((req_i.seed[31:24] & K2_MASK) ^ K2_FLIP);
          st_d = L_RUN;
        end
      end
      L_RUN: begin
        s_d = {s_q[WORD_W-2:0], fb};
        n_d = n_q - 7'd1;
        if (n_q == 7'd1) begin
          st_d = L_DONE;
        end
      end
      L_DONE:  st_d = L_IDLE;
      default: st_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= L_IDLE;
      n_q  <= '0;
    end else begin
      st_q <= st_d;
      n_q  <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign rsp_o.done = (st_q == L_DONE);
  assign rsp_o.key  = s_q ^ XOR2;

endmodule
`default_nettype wire

### sv/gateway_seed_key_responder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gateway_seed_key_responder_unit
// Decodes one received handshake frame and returns the reply frame, computing
// the seed keys on a digit-serial multiplier or a bit-serial shift register.
//
//   channel  dir  beat
//   cfg_i    in   response_id written into the reply identifier register
//   in_i     in   command nibble and rx_byte0..rx_byte4
//   out_o    out  send_frame, auth_done, length, frame id, tx_byte0..tx_byte5
//
// fixed replies pass the pending register, then the output register once free
// key two: one feedback bit per cycle
// key one: 20 multiply-reduce steps of six passes through the 32x8 serial
//   multiplier
// one frame is worked on at a time; a finished reply may wait in the output
//   register while the next frame is taken in
// reset clears the control state and response_id
// ----------------------------------------------------------------------------
module gateway_seed_key_responder_unit import gsk_pkg::*; #(
  parameter int unsigned DigitW = DIGIT_W
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  gsk_cfg_if.sink   cfg_i,
  gsk_in_if.sink    in_i,
  gsk_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_KEY  = 3'b010,
    S_PUSH = 3'b100
  } st_e;

  st_e         state_q, state_d;
  reply_t      dec, pend_q, pend_d, out_q, out_d;
  logic        need_k1, need_k2, in_fire;
  logic        out_valid_q, out_valid_d;
  logic [10:0] rid_q, out_rid_q, out_rid_d;
  key_req_t    k1_req, k2_req;
  key_rsp_t    k1_rsp, k2_rsp;
  logic [WORD_W-1:0] key;

  gsk_key1 #(.DigitW(DigitW)) u_key1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (k1_req),
    .rsp_o  (k1_rsp)
  );

  gsk_key2 u_key2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (k2_req),
    .rsp_o  (k2_rsp)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;

  // frame decode; fields of an unsent frame stay zero
  always_comb begin
    dec     = '0;
    need_k1 = 1'b0;
    need_k2 = 1'b0;
    unique case (in_i.command)
      CMD_FIRST: begin
        unique case (in_i.rx_byte0)
          SUB_01: begin
            dec.send  = 1'b1;
            dec.len   = LEN_2;
            dec.tx[0] = RSP_SESSION;
            dec.tx[1] = SUB_03;
          end
          SUB_03: begin
            dec.send  = 1'b1;
            dec.len   = LEN_6;
            dec.tx[0] = RSP_SECURITY;
            dec.tx[1] = SUB_41;
            dec.tx[2] = MOD1[15:8];
            dec.tx[3] = MOD1[7:0];
            dec.tx[5] = EXT_0D;
          end
          default: ;
        endcase
      end
      CMD_CONSEC: begin
        unique case (in_i.rx_byte0)
          SUB_41: begin
            dec.send  = 1'b1;
            dec.len   = LEN_6;
            dec.tx[0] = RSP_SECURITY;
            dec.tx[1] = SUB_42;
            need_k1   = 1'b1;
          end
          SUB_42: begin
            dec.send  = 1'b1;
            dec.len   = LEN_2;
            dec.tx[0] = RSP_SECURITY;
            dec.tx[1] = SUB_01;
          end
          SUB_01: begin
            dec.send  = 1'b1;
            dec.len   = LEN_6;
            dec.tx[0] = RSP_SECURITY;
            dec.tx[1] = SUB_02;
            need_k2   = 1'b1;
          end
          SUB_02: begin
            dec.send  = 1'b1;
            dec.len   = LEN_5;
            dec.tx[0] = RSP_ROUTINE;
            dec.tx[1] = SUB_01;
            dec.tx[2] = FILL_AA;
            dec.tx[3] = FILL_FF;
          end
          default: ;
        endcase
      end
      CMD_FLOW: begin
        unique case (in_i.rx_byte0)
          SUB_01: begin
            dec.send  = 1'b1;
            dec.len   = LEN_4;
            dec.tx[0] = RSP_ROUTINE;
            dec.tx[1] = SUB_03;
            dec.tx[2] = FILL_AA;
            dec.tx[3] = FILL_FF;
          end
          SUB_03:  dec.done = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign k1_req.start = in_fire && need_k1;
  assign k1_req.seed  = {in_i.rx_byte1, in_i.rx_byte2, in_i.rx_byte3, in_i.rx_byte4};
  assign k2_req.start = in_fire && need_k2;
  assign k2_req.seed  = k1_req.seed;
  assign key          = k1_rsp.done ? k1_rsp.key : k2_rsp.key;

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_rid_d   = out_rid_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          pend_d  = dec;
          state_d = (need_k1 || need_k2) ? S_KEY : S_PUSH;
        end
      end
      S_KEY: begin
        if (k1_rsp.done || k2_rsp.done) begin
          {pend_d.tx[2], pend_d.tx[3], pend_d.tx[4], pend_d.tx[5]} = key;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = pend_q;
          out_rid_d   = pend_q.send ? rid_q : '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rid_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        rid_q <= cfg_i.response_id;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    out_q     <= out_d;
    out_rid_q <= out_rid_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.send_frame        = out_q.send;
  assign out_o.auth_done         = out_q.done;
  assign out_o.frame_length      = out_q.len;
  assign out_o.response_frame_id = out_rid_q;
  assign out_o.tx_byte0          = out_q.tx[0];
  assign out_o.tx_byte1          = out_q.tx[1];
  assign out_o.tx_byte2          = out_q.tx[2];
  assign out_o.tx_byte3          = out_q.tx[3];
  assign out_o.tx_byte4          = out_q.tx[4];
  assign out_o.tx_byte5          = out_q.tx[5];

  a_key_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k1_req.start || k2_req.start) |=> state_q == S_KEY)
    else $error("key unit started without entering key wait");

  a_key_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({k1_rsp.done, k2_rsp.done}))
    else $error("both key units finished together");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("accepted frame left no work behind");

  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.send) |->
      (out_q.len == '0 && out_rid_q == '0 && out_q.tx == '0))
    else $error("unsent reply carries nonzero fields");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done) |-> !out_q.send)
    else $error("final acknowledgement also sends a frame");

endmodule
`default_nettype wire
